@@ design/kti_pkg.sv @@
// shared types and constants for the keyframe track interpolator
package kti_pkg;

    localparam int KEY_WORDS = 10;
    localparam int N_ATTR    = 9;

    localparam logic [1:0] CFG_DURATION  = 2'd0;
    localparam logic [1:0] CFG_CYCLE     = 2'd1;
    localparam logic [1:0] CFG_KEY_COUNT = 2'd2;
    localparam logic [1:0] CFG_RESERVED  = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_END,
        ST_T0_RD,
        ST_T1_RD,
        ST_DIV,
        ST_A_RD,
        ST_B_RD,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } kti_state_t;

    typedef struct packed {
        logic [3:0] seg;
        logic       paused;
    } kti_status_t;

endpackage

@@ design/kti_if.sv @@
// valid/ready channel interfaces for input words, results and configuration
interface kti_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  key_slot;
    logic [3:0]  key_word;
    logic signed [31:0] word_value;
    logic [31:0] elapsed;
    modport source (output valid, kind, key_slot, key_word, word_value, elapsed, input ready);
    modport sink   (input valid, kind, key_slot, key_word, word_value, elapsed, output ready);
endinterface

interface kti_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] yaw_out;
    logic signed [31:0] pitch_out;
    logic signed [31:0] roll_out;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic [3:0]  segment_index;
    logic        paused_flag;
    modport source (output valid, pos_x, pos_y, pos_z, yaw_out, pitch_out, roll_out,
                    scale_x, scale_y, scale_z, segment_index, paused_flag, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, yaw_out, pitch_out, roll_out,
                    scale_x, scale_y, scale_z, segment_index, paused_flag, output ready);
endinterface

interface kti_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/kti_divider.sv @@
// restoring divider, one quotient bit per cycle
module kti_divider
    import kti_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [FRAC_BITS-1:0] quo
);
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [32:0]          rem_reg, rem_next;
    logic [31:0]          den_reg, den_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [32:0]          trial;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], 1'b0} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            cnt_next  = CW'(FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so the doubled value fits 33 bits
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], 1'b0};
                quo_next = {quo_reg[FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quo  = quo_next;
endmodule

@@ design/keyframe_track_interpolator.sv @@
// keyframe track interpolator top level: key memory, sequencer and shared lerp unit
//
// in_ch carries words: kind 0 writes one keyframe word into the key memory,
// kind 1 is a tick that advances play time and yields one result on out_ch.
// cfg_ch writes track_duration, cycle_enable and key_count; the user must
// write them only while idle, the block does not enforce it. a load is
// written into the key memory and in_ch stays ready. a tick starts the
// key search, compares keys (one memory read per key), does end of track
// and segment setup, runs the fraction divider unless the fraction is
// zero or one, and sends each attribute through the single multiplier
// (read a, read b, subtract, multiply, write); in_ch is not ready meanwhile.
// the result sits in an output register until out_ch takes it; the next
// word is accepted only once the result has been taken.
// reset clears play time, segment, paused flag and configuration; key
// memory contents are undefined until written.
module keyframe_track_interpolator
    import kti_pkg::*;
#(
    parameter int MAX_KEYS  = 16,
    parameter int FRAC_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    kti_in_if.sink    in_ch,
    kti_out_if.source out_ch,
    kti_cfg_if.sink   cfg_ch
);
    localparam int KW    = $clog2(MAX_KEYS);
    localparam int AW    = $clog2(MAX_KEYS * KEY_WORDS);
    localparam int NW    = $clog2(MAX_KEYS + 1);
    localparam logic [NW-1:0] NMAX = NW'(MAX_KEYS);

    kti_state_t state_reg, state_next;

    logic [31:0] mem [MAX_KEYS*KEY_WORDS];
    logic [31:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;

    logic [31:0] duration_reg;
    logic        cycle_reg;
    logic [4:0]  count_reg;
    logic [31:0] time_reg, time_next;
    logic [KW-1:0] seg_reg, seg_next;
    logic        paused_reg, paused_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [31:0] t0_reg, t0_next;
    logic [FRAC_BITS:0] f_reg, f_next;
    logic [3:0]  attr_reg, attr_next;
    logic [31:0] a_reg, a_next;
    logic signed [32:0] d_reg, d_next;
    logic signed [FRAC_BITS+34:0] p_reg, p_next;
    logic [31:0] res_reg [N_ATTR];
    logic        res_we;
    logic        ovalid_reg, ovalid_next;
    logic        div_start, div_done;
    logic [FRAC_BITS-1:0] div_quo;
    logic [31:0] div_num, div_den;
    logic [NW-1:0] n;
    logic [KW-1:0] nm2;
    logic [32:0] tsum;
    kti_status_t status_reg;

    always_comb
    begin
        if (count_reg < 5'd2)
            n = NW'(2);
        else if (32'(count_reg) > MAX_KEYS)
            n = NMAX;
        else
            n = NW'(count_reg);
        nm2 = KW'(n - NW'(2));
    end

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= '0;
            cycle_reg    <= 1'b0;
            count_reg    <= 5'd2;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_DURATION:  duration_reg <= cfg_ch.data;
                CFG_CYCLE:     cycle_reg    <= cfg_ch.data[0];
                CFG_KEY_COUNT: count_reg    <= cfg_ch.data[4:0];
                default: ;
            endcase
        end
    end

    assign wr_addr = AW'(in_ch.key_slot * KEY_WORDS + in_ch.key_word);
    assign wr_en   = (state_reg == ST_IDLE) && in_ch.valid && !ovalid_reg &&
                     (in_ch.kind == KIND_LOAD) && (32'(in_ch.key_slot) < MAX_KEYS) &&
                     (in_ch.key_word < 4'(KEY_WORDS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_ch.word_value;
        rd_data <= mem[rd_addr];
    end

    assign div_num = time_reg - t0_reg;
    assign div_den = rd_data - t0_reg;

    kti_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_ch.ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign tsum = {1'b0, time_reg} + {1'b0, in_ch.elapsed};

    always_comb
    begin
        state_next  = state_reg;
        time_next   = time_reg;
        seg_next    = seg_reg;
        paused_next = paused_reg;
        idx_next    = idx_reg;
        t0_next     = t0_reg;
        f_next      = f_reg;
        attr_next   = attr_reg;
        a_next      = a_reg;
        d_next      = d_reg;
        p_next      = p_reg;
        ovalid_next = ovalid_reg;
        div_start   = 1'b0;
        res_we      = 1'b0;
        rd_addr     = '0;
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && !ovalid_reg && in_ch.kind == KIND_TICK)
                begin
                    if (!paused_reg)
                        time_next = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                    idx_next   = '0;
                    state_next = ST_SEARCH_RD;
                end
            end
            ST_SEARCH_RD:
            begin
                rd_addr    = AW'(idx_reg * KEY_WORDS);
                state_next = ST_SEARCH_CMP;
            end
            ST_SEARCH_CMP:
            begin
                if (rd_data > time_reg)
                begin
                    seg_next   = (idx_reg == '0) ? '0 : KW'(idx_reg - 1'b1);
                    state_next = ST_END;
                end
                else if (idx_reg + 1'b1 >= n)
                    state_next = ST_END;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = AW'((idx_reg + 1'b1) * KEY_WORDS);
                    state_next = ST_SEARCH_CMP;
                end
                if (state_next == ST_SEARCH_CMP)
                    state_next = ST_SEARCH_CMP;
            end
            ST_END:
            begin
                if (time_reg >= duration_reg)
                begin
                    if (cycle_reg)
                    begin
                        seg_next  = '0;
                        time_next = '0;
                    end
                    else
                    begin
                        seg_next    = nm2;
                        time_next   = duration_reg;
                        paused_next = 1'b1;
                    end
                end
                else if (seg_reg > nm2)
                    seg_next = nm2;
                state_next = ST_T0_RD;
            end
            ST_T0_RD:
            begin
                if (seg_reg > nm2)
                    seg_next = nm2;
                rd_addr    = AW'(((seg_reg > nm2) ? nm2 : seg_reg) * KEY_WORDS);
                state_next = ST_T1_RD;
            end
            ST_T1_RD:
            begin
                t0_next    = rd_data;
                rd_addr    = AW'((seg_reg + 1'b1) * KEY_WORDS);
                state_next = ST_DIV;
                attr_next  = 4'd0;
            end
            ST_DIV:
            begin
                // rd_data holds t1 here on the first cycle only; decide then
                if (attr_reg == 4'd0)
                begin
                    attr_next = 4'd1;
                    if (rd_data <= t0_reg || time_reg <= t0_reg)
                    begin
                        f_next     = '0;
                        attr_next  = 4'd0;
                        state_next = ST_A_RD;
                    end
                    else if (div_num >= div_den)
                    begin
                        f_next     = (FRAC_BITS+1)'(1) << FRAC_BITS;
                        attr_next  = 4'd0;
                        state_next = ST_A_RD;
                    end
                    else
                        div_start = 1'b1;
                end
                else if (div_done)
                begin
                    f_next     = {1'b0, div_quo};
                    attr_next  = 4'd0;
                    state_next = ST_A_RD;
                end
            end
            ST_A_RD:
            begin
                rd_addr    = AW'(seg_reg * KEY_WORDS + attr_reg + 1'b1);
                state_next = ST_B_RD;
            end
            ST_B_RD:
            begin
                a_next     = rd_data;
                rd_addr    = AW'((seg_reg + 1'b1) * KEY_WORDS + attr_reg + 1'b1);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                d_next     = 33'(signed'(rd_data)) - 33'(signed'(a_reg));
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                p_next = d_reg * signed'({1'b0, f_reg})
                         + ((FRAC_BITS+35)'(1) <<< (FRAC_BITS-1));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // arithmetic shift is floor division; matches the model's rounding
                res_we = 1'b1;
                if (attr_reg == 4'(N_ATTR-1))
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    attr_next  = attr_reg + 1'b1;
                    state_next = ST_A_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            time_reg   <= '0;
            seg_reg    <= '0;
            paused_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            status_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            seg_reg    <= seg_next;
            paused_reg <= paused_next;
            ovalid_reg <= ovalid_next;
            if (res_we && attr_reg == 4'(N_ATTR-1))
            begin
                status_reg.seg    <= 4'(seg_reg);
                status_reg.paused <= paused_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        t0_reg   <= t0_next;
        f_reg    <= f_next;
        attr_reg <= attr_next;
        a_reg    <= a_next;
        d_reg    <= d_next;
        p_reg    <= p_next;
        if (res_we)
            res_reg[attr_reg] <= a_reg + 32'(p_reg >>> FRAC_BITS);
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.pos_x         = res_reg[0];
    assign out_ch.pos_y         = res_reg[1];
    assign out_ch.pos_z         = res_reg[2];
    assign out_ch.yaw_out       = res_reg[3];
    assign out_ch.pitch_out     = res_reg[4];
    assign out_ch.roll_out      = res_reg[5];
    assign out_ch.scale_x       = res_reg[6];
    assign out_ch.scale_y       = res_reg[7];
    assign out_ch.scale_z       = res_reg[8];
    assign out_ch.segment_index = status_reg.seg;
    assign out_ch.paused_flag   = status_reg.paused;
endmodule

@@ tb/keyframe_track_interpolator_tb.sv @@
// self-checking testbench for the keyframe track interpolator
`timescale 1ns / 100ps

module keyframe_track_interpolator_tb
    import kti_pkg::*;
();

    localparam int NKEYS     = 16;
    localparam int FBITS     = 16;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 100;
    localparam int HOLD_LEN  = 400;
    localparam int W_TIME    = 0;
    localparam int W_POS_X   = 1;
    localparam int W_SCALE_Z = 9;

    typedef struct packed {
        logic [N_ATTR-1:0][31:0] attr;
        logic [3:0]              seg;
        logic                    paused;
    } pose_t;

    logic clk;
    logic rst_n;

    kti_in_if  in_ch();
    kti_out_if out_ch();
    kti_cfg_if cfg_ch();

    keyframe_track_interpolator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // predictor state
    logic [31:0] key_mem [NKEYS][KEY_WORDS];
    logic [31:0] play_t;
    int          cur_seg;
    logic        halted;
    logic [31:0] dur_reg;
    logic        cyc_reg;
    logic [4:0]  kcnt_reg;

    pose_t pose_q[$];
    int    err_count;
    int    cycles;
    bit    idle_en;
    bit    hold_req;
    int    hold_left;
    int    stall_left;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] lerp_attr(logic [31:0] a, logic [31:0] b,
                                              longint unsigned f);
        longint d;
        longint p;
        longint q;
        d = longint'($signed(b)) - longint'($signed(a));
        p = d * longint'(f) + (longint'(1) <<< (FBITS - 1));
        q = p >>> FBITS;
        return 32'(longint'($signed(a)) + q);
    endfunction

    function automatic pose_t advance_track(logic [31:0] el);
        int              n;
        logic [32:0]     sum;
        logic [31:0]     t0;
        logic [31:0]     t1;
        longint unsigned f;
        longint unsigned num;
        longint unsigned den;
        pose_t           r;
        n = (kcnt_reg < 2) ? 2 : (kcnt_reg > NKEYS) ? NKEYS : int'(kcnt_reg);
        if (!halted)
        begin
            sum = {1'b0, play_t} + {1'b0, el};
            play_t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        for (int i = 0; i < n; i++)
        begin
            if (key_mem[i][W_TIME] > play_t)
            begin
                cur_seg = (i == 0) ? 0 : i - 1;
                break;
            end
        end
        if (play_t >= dur_reg)
        begin
            if (cyc_reg)
            begin
                cur_seg = 0;
                play_t = '0;
            end
            else
            begin
                cur_seg = n - 2;
                play_t = dur_reg;
                halted = 1'b1;
            end
        end
        if (cur_seg > n - 2)
            cur_seg = n - 2;
        t0 = key_mem[cur_seg][W_TIME];
        t1 = key_mem[cur_seg + 1][W_TIME];
        if (t1 <= t0 || play_t <= t0)
            f = 0;
        else
        begin
            num = play_t - t0;
            den = t1 - t0;
            if (num >= den)
                f = longint'(1) << FBITS;
            else
                f = (num << FBITS) / den;
        end
        for (int j = 0; j < N_ATTR; j++)
            r.attr[j] = lerp_attr(key_mem[cur_seg][j+1], key_mem[cur_seg+1][j+1], f);
        r.seg = 4'(cur_seg);
        r.paused = halted;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
        err_count++;
    endtask

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pose_t got;
        pose_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.attr[0] = out_ch.pos_x;
            got.attr[1] = out_ch.pos_y;
            got.attr[2] = out_ch.pos_z;
            got.attr[3] = out_ch.yaw_out;
            got.attr[4] = out_ch.pitch_out;
            got.attr[5] = out_ch.roll_out;
            got.attr[6] = out_ch.scale_x;
            got.attr[7] = out_ch.scale_y;
            got.attr[8] = out_ch.scale_z;
            got.seg = out_ch.segment_index;
            got.paused = out_ch.paused_flag;
            if (pose_q.size() == 0)
                report_mismatch("unexpected result", '0, '0);
            else
            begin
                want = pose_q.pop_front();
                for (int j = 0; j < N_ATTR; j++)
                    if (got.attr[j] !== want.attr[j])
                        report_mismatch($sformatf("attr%0d", j), got.attr[j], want.attr[j]);
                if (got.seg !== want.seg)
                    report_mismatch("segment_index", 32'(got.seg), 32'(want.seg));
                if (got.paused !== want.paused)
                    report_mismatch("paused_flag", 32'(got.paused), 32'(want.paused));
            end
        end
    end

    task automatic send_word(logic kind, logic [3:0] slot, logic [3:0] word,
                             logic [31:0] value, logic [31:0] el);
        int    gap;
        pose_t nxt;
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.key_slot   <= slot;
        in_ch.key_word   <= word;
        in_ch.word_value <= value;
        in_ch.elapsed    <= el;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (kind == KIND_TICK)
        begin
            nxt = advance_track(el);
            pose_q.insert(pose_q.size(), nxt);
        end
        else if (word < KEY_WORDS)
            key_mem[slot][word] = value;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tick(logic [31:0] el);
        send_word(KIND_TICK, 4'($urandom), 4'($urandom), $urandom, el);
    endtask

    task automatic load(int slot, int word, logic [31:0] value);
        send_word(KIND_LOAD, 4'(slot), 4'(word), value, $urandom);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_DURATION:  dur_reg = value;
            CFG_CYCLE:     cyc_reg = value[0];
            CFG_KEY_COUNT: kcnt_reg = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_track(logic [31:0] d, logic c, logic [4:0] k);
        write_reg(CFG_DURATION, d);
        write_reg(CFG_CYCLE, {31'($urandom), c});
        write_reg(CFG_KEY_COUNT, {27'($urandom), k});
    endtask

    // increasing key times with random steps, returns the last key time
    task automatic lay_out_times(int max_step, output logic [31:0] last_t);
        logic [31:0] t;
        t = $urandom_range(0, max_step);
        for (int i = 0; i < NKEYS; i++)
        begin
            load(i, W_TIME, t);
            last_t = t;
            t = t + $urandom_range(1, max_step);
        end
    endtask

    task automatic test_fill_table();
        logic [31:0] last_t;
        for (int i = 0; i < NKEYS; i++)
            for (int w = W_POS_X; w <= W_SCALE_Z; w++)
                load(i, w, $urandom);
        lay_out_times(32'h0001_0000, last_t);
        for (int i = 0; i < NKEYS; i++)
            load(i, W_TIME, i * 32'h0001_0000);
    endtask

    task automatic test_directed();
        set_track(32'h000F_0000, 1'b1, 5'd16);
        tick(32'h0);
        tick(32'h0000_8000);
        tick(32'h0001_8000);
        tick(32'h0000_8000);
        // attribute extremes in one segment
        load(3, W_POS_X, 32'h7FFF_FFFF);
        load(4, W_POS_X, 32'h8000_0000);
        load(3, 5, 32'h8000_0000);
        load(4, 5, 32'h7FFF_FFFF);
        tick(32'h0000_8000);
        // codes past the last word are dropped
        load(4, 10, $urandom);
        load(4, 15, $urandom);
        // end of track wraps back to zero
        tick(32'h000E_0000);
        // two keys with the same time
        load(1, W_TIME, 32'h0000_0000);
        tick(32'h0000_4000);
        tick(32'h0000_8000);
        load(1, W_TIME, 32'h0001_0000);
        // saturation of play time
        set_track(32'hFFFF_FFFF, 1'b1, 5'd16);
        tick(32'h000A_8000);
        tick(32'hFFFF_FFFF);
        tick(32'h000B_0000);
        // shrinking key count leaves the segment out of range
        set_track(32'hFFFF_FFFF, 1'b1, 5'd3);
        tick(32'h0);
        set_track(32'hFFFF_FFFF, 1'b1, 5'd0);
        tick(32'h0000_1000);
        set_track(32'hFFFF_FFFF, 1'b1, 5'd31);
        tick(32'h0008_0000);
        // zero duration
        set_track(32'h0, 1'b1, 5'd16);
        tick(32'h0001_0000);
        tick(32'h0);
        write_reg(CFG_RESERVED, $urandom);
        tick(32'h0000_1000);
    endtask

    task automatic random_phase(int items, int max_step, int dur_mode, int kc);
        logic [31:0] last_t;
        logic [31:0] d;
        int          n;
        lay_out_times(max_step, last_t);
        n = (kc < 2) ? 2 : (kc > NKEYS) ? NKEYS : kc;
        case (dur_mode)
            0: d = key_mem[n-1][W_TIME] + $urandom_range(0, max_step);
            1: d = 32'hFFFF_FFFF;
            2: d = '0;
            default: d = $urandom_range(0, key_mem[n-1][W_TIME]);
        endcase
        set_track(d, 1'b1, 5'(kc));
        for (int k = 0; k < items; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: load($urandom_range(0, NKEYS-1),
                                 $urandom_range(W_POS_X, W_SCALE_Z), $urandom);
                4: send_word(KIND_LOAD, 4'($urandom), 4'($urandom_range(KEY_WORDS, 15)),
                             $urandom, $urandom);
                5: load($urandom_range(0, NKEYS-1), W_TIME, $urandom_range(0, last_t));
                6: tick($urandom);
                7: tick(32'h0);
                default: tick($urandom_range(0, max_step));
            endcase
        end
    endtask

    task automatic test_random();
        random_phase(250, 32'h0000_4000, 0, 16);
        random_phase(200, 32'h0002_0000, 3, $urandom_range(2, 16));
        random_phase(150, 32'h0100_0000, 1, 16);
        random_phase(80, 32'h0000_0800, 2, 5);
        random_phase(200, 32'h0000_2000, 0, 2);
        random_phase(150, 32'h0008_0000, 0, $urandom_range(17, 31));
        random_phase(200, 32'h0000_8000, 3, $urandom_range(0, 1));
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            tick($urandom_range(0, 32'h0000_4000));
    endtask

    task automatic test_pause();
        logic [31:0] last_t;
        lay_out_times(32'h0000_4000, last_t);
        set_track(last_t - 32'h0000_2000, 1'b0, 5'd16);
        while (!halted)
            tick($urandom_range(0, 32'h0000_8000));
        for (int k = 0; k < 40; k++)
        begin
            tick($urandom);
            if ($urandom_range(0, 2) == 0)
                load($urandom_range(0, NKEYS-1), $urandom_range(W_POS_X, W_SCALE_Z), $urandom);
        end
        write_reg(CFG_KEY_COUNT, 32'd4);
        tick($urandom);
        write_reg(CFG_KEY_COUNT, 32'd16);
        idle_en = 1'b0;
        for (int k = 0; k < 60; k++)
            tick($urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        err_count = 0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_LOAD;
        in_ch.key_slot = '0;
        in_ch.key_word = '0;
        in_ch.word_value = '0;
        in_ch.elapsed = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_DURATION;
        cfg_ch.data = '0;
        play_t = '0;
        cur_seg = 0;
        halted = 1'b0;
        dur_reg = '0;
        cyc_reg = 1'b0;
        kcnt_reg = 5'd2;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_directed();
        test_random();
        test_backpressure();
        test_pause();

        drain();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/kti_pkg.sv
design/kti_if.sv
design/kti_divider.sv
design/keyframe_track_interpolator.sv
tb/keyframe_track_interpolator_tb.sv
